/* rtl/core/sqlkw_pkg.sv */
package sqlkw_pkg;

    localparam int CH_W      = 8;
    localparam int KWNUM_W   = 8;
    localparam int LEN_W     = 5;
    localparam int KW_MAXLEN = 17;
    localparam int KW_COUNT  = 145;
    localparam int TEXT_W    = KW_MAXLEN * CH_W;

    localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CH_W-1:0] CH_CASE_BIT   = 8'h20;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
        logic            last;
    } sqlkw_in_t;

    typedef struct packed {
        logic               found;
        logic [KWNUM_W-1:0] keyword_number;
        logic [LEN_W-1:0]   match_length;
    } sqlkw_out_t;

    // request handed from the gather stage to the compare stage
    typedef struct packed {
        logic              judge;
        logic              bad_lead;
        logic              overflow;
        logic [LEN_W-1:0]  len;
        logic [TEXT_W-1:0] text;
    } sqlkw_run_t;

    function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
            r = c & ~CH_CASE_BIT;
        return r;
    endfunction

    function automatic logic is_word(input logic [CH_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_lead(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] u;
        u = to_upper(c);
        return (u >= 8'h41 && u <= 8'h5A) && (u != 8'h51) && (u != 8'h58);
    endfunction

    // keyword table: text left aligned (char 0 in the low byte), and its length
    function automatic logic [TEXT_W-1:0] pack_kw(input string s);
        logic [TEXT_W-1:0] r;
        r = '0;
        for (int i = 0; i < s.len(); i++)
            r[i*CH_W +: CH_W] = s[i];
        return r;
    endfunction

    function automatic string kw_str(input int k);
        string s;
        case (k)
            0: s = "AND"; 1: s = "AS"; 2: s = "AVG"; 3: s = "ALTER"; 4: s = "ALL";
            5: s = "ANY"; 6: s = "ACTION"; 7: s = "AT"; 8: s = "ADD";
            9: s = "AUTHORIZATION"; 10: s = "BETWEEN"; 11: s = "BY"; 12: s = "BIT";
            13: s = {"BIT_", "LENGTH"}; 14: s = "BOTH"; 15: s = "COUNT";
            16: s = "COMMIT"; 17: s = "CREATE"; 18: s = {"CURRENT_", "DATE"};
            19: s = {"CURRENT_", "TIME"}; 20: s = {"CURRENT_", "TIMESTAMP"};
            21: s = {"CURRENT_", "USER"}; 22: s = "COALESCE";
            23: s = "CASE"; 24: s = "CROSS"; 25: s = "CONVERT";
            26: s = {"CHAR_", "LENGTH"}; 27: s = {"CHARACTER_", "LENGTH"};
            28: s = "CHAR"; 29: s = "CHARACTER";
            30: s = "CASCADE"; 31: s = "CHECK"; 32: s = "COLUMN"; 33: s = "COLLATE";
            34: s = "COLLATION"; 35: s = "CONSTRAINT"; 36: s = "CASCADED";
            37: s = "DELETE"; 38: s = "DISTINCT"; 39: s = "DATE"; 40: s = "DAY";
            41: s = "DEC"; 42: s = "DECIMAL"; 43: s = "DEFAULT"; 44: s = "DROP";
            45: s = "DOUBLE"; 46: s = "DOMAIN"; 47: s = "EXISTS"; 48: s = "END";
            49: s = "ELSE"; 50: s = "EXTRACT"; 51: s = "ESCAPE"; 52: s = "FROM";
            53: s = "FOR"; 54: s = "FLOAT"; 55: s = "FULL"; 56: s = "FOREIGN";
            57: s = "GROUP"; 58: s = "GLOBAL"; 59: s = "GRANT"; 60: s = "HAVING";
            61: s = "HOUR"; 62: s = "IN"; 63: s = "INSERT"; 64: s = "INTO"; 65: s = "IS";
            66: s = "INNER"; 67: s = "INTERVAL"; 68: s = "INT"; 69: s = "INTEGER";
            70: s = "JOIN"; 71: s = "KEY"; 72: s = "LIKE"; 73: s = "LEFT";
            74: s = "LOWER"; 75: s = "LOCAL"; 76: s = "LEADING"; 77: s = "MAX";
            78: s = "MIN"; 79: s = "MATCH"; 80: s = "MINUTE"; 81: s = "MONTH";
            82: s = "NOT"; 83: s = "NO"; 84: s = "NULL"; 85: s = "NULLIF";
            86: s = "NATURAL"; 87: s = "NATIONAL"; 88: s = "NCHAR"; 89: s = "NUMERIC";
            90: s = "OR"; 91: s = "ON"; 92: s = "OUTER"; 93: s = {"OCTET_", "LENGTH"};
            94: s = "OPTION"; 95: s = "OVERLAPS"; 96: s = "POSITION";
            97: s = "PRECISION"; 98: s = "PRIMARY"; 99: s = "PARTIAL";
            100: s = "PRIVILEGES"; 101: s = "PUBLIC"; 102: s = "ROLLBACK";
            103: s = "RIGHT"; 104: s = "REAL"; 105: s = "REFERENCES";
            106: s = "RESTRICT"; 107: s = "SELECT"; 108: s = "SET"; 109: s = "SUM";
            110: s = "SCHEMA"; 111: s = "SECOND"; 112: s = "SUBSTRING";
            113: s = "SMALLINT"; 114: s = {"SESSION_", "USER"};
            115: s = {"SYSTEM_", "USER"};
            116: s = "SOME"; 117: s = "TABLE"; 118: s = "TIME"; 119: s = "TIMESTAMP";
            120: s = "TEMPORARY"; 121: s = "TRIM"; 122: s = "THEN"; 123: s = "TO";
            124: s = "TRAILING"; 125: s = "TRANSLATE"; 126: s = "TRANSLATION";
            127: s = "UPDATE"; 128: s = "UPPER"; 129: s = "USING"; 130: s = "UNION";
            131: s = "USER"; 132: s = "UNIQUE"; 133: s = "USAGE"; 134: s = "VALUES";
            135: s = "VARCHAR"; 136: s = "VARYING"; 137: s = "VIEW"; 138: s = "VALUE";
            139: s = "WHERE"; 140: s = "WITH"; 141: s = "WHEN"; 142: s = "WORK";
            143: s = "YEAR"; 144: s = "ZONE";
            default: s = "";
        endcase
        return s;
    endfunction

    function automatic logic [TEXT_W-1:0] kw_text(input int k);
        return pack_kw(kw_str(k));
    endfunction

    function automatic logic [LEN_W-1:0] kw_len(input int k);
        string s;
        s = kw_str(k);
        return LEN_W'(s.len());
    endfunction

endpackage

/* rtl/core/sqlkw_stream_if.sv */
interface sqlkw_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/sql_keyword_recognizer_unit.sv */
// Result: registered at the edge that accepts the byte closing the run, and
// valid in the following cycle.
// Throughput: one byte per cycle; the output register holds a result while
// the sink stalls, and input is taken whenever that register is free or drains.
// Reset: asynchronous active low; clears the run length, overflow and open
// flags and the result valid, the run buffer and result data are not cleared.
module sql_keyword_recognizer_unit
    import sqlkw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    sqlkw_stream_if.sink         in_ch,
    sqlkw_stream_if.source       out_ch
);

    logic       take;
    sqlkw_run_t run;
    sqlkw_out_t res;
    sqlkw_out_t res_reg;
    logic       valid_reg, valid_next;

    assign in_ch.ready = !valid_reg || out_ch.ready;
    assign take        = in_ch.valid && in_ch.ready;

    sqlkw_gather u_gather (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_data (in_ch.data),
        .run     (run)
    );

    sqlkw_match u_match (
        .run (run),
        .res (res)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ch.ready)
            valid_next = 1'b0;
        if (take && run.judge)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && run.judge)
            res_reg <= res;
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.data  = res_reg;

endmodule

/* rtl/core/sqlkw_gather.sv */
module sqlkw_gather
    import sqlkw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  sqlkw_in_t  in_data,
    output sqlkw_run_t run
);

    logic [CH_W-1:0]  store_reg [KW_MAXLEN];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             open_reg, open_next;
    logic             add;
    logic             judge;
    logic             bad_lead;
    logic [LEN_W-1:0] base_len;
    logic             base_ovf;
    logic [TEXT_W-1:0] text;

    always_comb
    begin
        open_next = open_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        add       = 1'b0;
        judge     = 1'b0;
        bad_lead  = 1'b0;
        base_len  = len_reg;
        base_ovf  = ovf_reg;
        if (take)
        begin
            if (in_data.first)
            begin
                base_len = '0;
                base_ovf = 1'b0;
                if (!is_lead(in_data.ch))
                begin
                    judge     = 1'b1;
                    bad_lead  = 1'b1;
                    open_next = 1'b0;
                end
                else
                begin
                    add       = 1'b1;
                    open_next = !in_data.last;
                    judge     = in_data.last;
                end
            end
            else if (open_reg)
            begin
                if (!is_word(in_data.ch))
                begin
                    judge     = 1'b1;
                    open_next = 1'b0;
                end
                else
                begin
                    add       = 1'b1;
                    judge     = in_data.last;
                    open_next = !in_data.last;
                end
            end
        end
        len_next = base_len;
        ovf_next = base_ovf;
        if (add)
        begin
            if (base_len < LEN_W'(KW_MAXLEN))
                len_next = base_len + 1'b1;
            else
                ovf_next = 1'b1;
        end
    end

    // the judged text includes the byte taken in this cycle
    always_comb
    begin
        for (int i = 0; i < KW_MAXLEN; i++)
            text[i*CH_W +: CH_W] = (add && base_len == LEN_W'(i)) ?
                to_upper(in_data.ch) : store_reg[i];
    end

    assign run = {judge, bad_lead, ovf_next, len_next, text};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            open_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KW_MAXLEN; i++)
            if (add && base_len == LEN_W'(i))
                store_reg[i] <= to_upper(in_data.ch);
    end

endmodule

/* rtl/core/sqlkw_match.sv */
module sqlkw_match
    import sqlkw_pkg::*;
(
    input  sqlkw_run_t run,
    output sqlkw_out_t res
);

    logic [KW_COUNT-1:0] hit;

    // one comparator per keyword, all in parallel
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
            hit[k] = (run.len == kw_len(k)) &&
                     (((run.text ^ kw_text(k)) &
                       ((TEXT_W'(1) << (run.len * CH_W)) - TEXT_W'(1))) == '0);
    end

    // no two keywords are equal, so at most one hit
    always_comb
    begin
        res = '0;
        if (!run.bad_lead && !run.overflow && run.len != '0)
        begin
            for (int k = 0; k < KW_COUNT; k++)
                if (hit[k])
                begin
                    res.found          = 1'b1;
                    res.keyword_number = KWNUM_W'(k);
                    res.match_length   = run.len;
                end
        end
    end

endmodule

/* dv/sqlkw_tb_pkg.sv */
package sqlkw_tb_pkg;
    import sqlkw_pkg::*;

    // keyword list kept here for the lookup model
    localparam string KEYWORDS [KW_COUNT] = '{
        "AND", "AS", "AVG", "ALTER", "ALL", "ANY", "ACTION", "AT", "ADD",
        "AUTHORIZATION", "BETWEEN", "BY", "BIT", {"BIT_", "LENGTH"}, "BOTH",
        "COUNT", "COMMIT", "CREATE", {"CURRENT_", "DATE"}, {"CURRENT_", "TIME"},
        {"CURRENT_", "TIMESTAMP"}, {"CURRENT_", "USER"}, "COALESCE", "CASE", "CROSS",
        "CONVERT", {"CHAR_", "LENGTH"}, {"CHARACTER_", "LENGTH"}, "CHAR", "CHARACTER",
        "CASCADE", "CHECK", "COLUMN", "COLLATE", "COLLATION", "CONSTRAINT",
        "CASCADED", "DELETE", "DISTINCT", "DATE", "DAY", "DEC", "DECIMAL",
        "DEFAULT", "DROP", "DOUBLE", "DOMAIN", "EXISTS", "END", "ELSE",
        "EXTRACT", "ESCAPE", "FROM", "FOR", "FLOAT", "FULL", "FOREIGN",
        "GROUP", "GLOBAL", "GRANT", "HAVING", "HOUR", "IN", "INSERT", "INTO",
        "IS", "INNER", "INTERVAL", "INT", "INTEGER", "JOIN", "KEY", "LIKE",
        "LEFT", "LOWER", "LOCAL", "LEADING", "MAX", "MIN", "MATCH", "MINUTE",
        "MONTH", "NOT", "NO", "NULL", "NULLIF", "NATURAL", "NATIONAL",
        "NCHAR", "NUMERIC", "OR", "ON", "OUTER", {"OCTET_", "LENGTH"}, "OPTION",
        "OVERLAPS", "POSITION", "PRECISION", "PRIMARY", "PARTIAL",
        "PRIVILEGES", "PUBLIC", "ROLLBACK", "RIGHT", "REAL", "REFERENCES",
        "RESTRICT", "SELECT", "SET", "SUM", "SCHEMA", "SECOND", "SUBSTRING",
        "SMALLINT", {"SESSION_", "USER"}, {"SYSTEM_", "USER"}, "SOME", "TABLE", "TIME",
        "TIMESTAMP", "TEMPORARY", "TRIM", "THEN", "TO", "TRAILING",
        "TRANSLATE", "TRANSLATION", "UPDATE", "UPPER", "USING", "UNION",
        "USER", "UNIQUE", "USAGE", "VALUES", "VARCHAR", "VARYING", "VIEW",
        "VALUE", "WHERE", "WITH", "WHEN", "WORK", "YEAR", "ZONE"
    };

    class keyword_scoreboard;
        logic [CH_W-1:0] run_chars [KW_MAXLEN];
        int              run_len;
        bit              gathering;
        sqlkw_out_t      pending_results [$];
        int              errors;
        int              results_seen;
        int              hits_seen;

        function void clear();
            run_len = 0;
            gathering = 0;
            pending_results.delete();
        endfunction

        function logic [CH_W-1:0] upcase(input logic [CH_W-1:0] c);
            return (c >= "a" && c <= "z") ? c - 8'd32 : c;
        endfunction

        function bit word_char(input logic [CH_W-1:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == "_";
        endfunction

        function void append(input logic [CH_W-1:0] c);
            if (run_len < KW_MAXLEN)
            begin
                run_chars[run_len] = c;
                run_len++;
            end
            else
                run_len = KW_MAXLEN + 1;
        endfunction

        function sqlkw_out_t lookup_run();
            sqlkw_out_t r;
            bit same;
            r = '0;
            gathering = 0;
            if (run_len == 0 || run_len > KW_MAXLEN)
                return r;
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (KEYWORDS[k].len() != run_len)
                    continue;
                same = 1;
                for (int i = 0; i < run_len; i++)
                    if (upcase(run_chars[i]) != KEYWORDS[k][i])
                        same = 0;
                if (same)
                begin
                    r.found = 1;
                    r.keyword_number = KWNUM_W'(k);
                    r.match_length = LEN_W'(run_len);
                    return r;
                end
            end
            return r;
        endfunction

        function void note_request(input sqlkw_in_t req);
            logic [CH_W-1:0] u;
            if (req.first)
            begin
                run_len = 0;
                gathering = 0;
                u = upcase(req.ch);
                if (!(u >= "A" && u <= "Z") || u == "Q" || u == "X")
                begin
                    pending_results.push_back('0);
                    return;
                end
                append(req.ch);
                gathering = 1;
                if (req.last)
                    pending_results.push_back(lookup_run());
                return;
            end
            if (!gathering)
                return;
            if (!word_char(req.ch))
            begin
                pending_results.push_back(lookup_run());
                return;
            end
            append(req.ch);
            if (req.last)
                pending_results.push_back(lookup_run());
        endfunction

        task report(input string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_result(input sqlkw_out_t got);
            sqlkw_out_t want;
            results_seen++;
            if (got.found)
                hits_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b want %b", got.found, want.found));
            if (got.keyword_number !== want.keyword_number)
                report($sformatf("keyword_number %0d want %0d",
                                 got.keyword_number, want.keyword_number));
            if (got.match_length !== want.match_length)
                report($sformatf("match_length %0d want %0d",
                                 got.match_length, want.match_length));
        endtask
    endclass
endpackage

/* dv/testbench.sv */
module testbench;
    import sqlkw_pkg::*;
    import sqlkw_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic clk = 0;
    logic rst_n = 0;
    int   send_idle_pct = 16;
    int   recv_idle_pct = 69;
    int   quiet_cycles = 0;
    int   requests_sent = 0;

    keyword_scoreboard board;

    sqlkw_stream_if #(.T(sqlkw_in_t))  in_ch ();
    sqlkw_stream_if #(.T(sqlkw_out_t)) out_ch ();

    sql_keyword_recognizer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        board = new();
        board.clear();
    end

    always @(posedge clk)
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.data);
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_request(in_ch.data);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // one request; valid stays high across back-to-back requests
    task send_byte(input logic [CH_W-1:0] c, input bit f, input bit l);
        sqlkw_in_t req;
        req.ch = c;
        req.first = f;
        req.last = l;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= req;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == 0, mark_last && i == s.len() - 1);
    endtask

    function logic [CH_W-1:0] random_word_char();
        case ($urandom_range(3))
            0: return 8'($urandom_range("a", "z"));
            1: return 8'($urandom_range("A", "Z"));
            2: return 8'($urandom_range("0", "9"));
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    function logic [CH_W-1:0] random_delim();
        logic [CH_W-1:0] c;
        c = 8'($urandom);
        while (board.word_char(c))
            c = 8'($urandom);
        return c;
    endfunction

    // keyword in random case, ended by a delimiter or by last
    task send_keyword(input int k);
        string s;
        bit by_last;
        s = KEYWORDS[k];
        by_last = 1'($urandom_range(1));
        for (int i = 0; i < s.len(); i++)
            send_byte(($urandom_range(1) != 0 && s[i] >= "A" && s[i] <= "Z") ?
                      (s[i] | CH_CASE_BIT) : s[i],
                      i == 0, by_last && i == s.len() - 1);
        if (!by_last)
            send_byte(random_delim(), 0, 1'($urandom_range(1)));
    endtask

    task send_random_run();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 8);
        send_byte(8'($urandom_range(1) ? $urandom_range("a", "z") : $urandom_range("A", "Z")),
                  1, n == 1 && $urandom_range(1) != 0);
        for (int i = 1; i < n; i++)
            send_byte(random_word_char(), 0, i == n - 1 && $urandom_range(1) != 0);
        if ($urandom_range(1))
            send_byte(random_delim(), 0, 0);
    endtask

    task wait_drained();
        in_ch.valid <= 0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task run_phase(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_keyword($urandom_range(KW_COUNT - 1));
            else if (r < 75)
                send_random_run();
            else if (r < 85)
                send_byte(8'($urandom), 1, 1'($urandom_range(1)));
            else
                send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every byte value as a lead, plus the corner cases
        send_text(KEYWORDS[20], 1);
        send_text("select", 0);
        send_byte(8'hFF, 0, 0);
        send_text("aNd", 1);
        send_text("zone", 0);
        send_byte(" ", 0, 1);
        send_byte("q", 1, 0);
        send_byte("X", 1, 1);
        send_byte(8'h00, 1, 0);
        send_byte(8'h80, 1, 0);
        send_byte("_", 1, 0);
        send_byte("a", 1, 1);
        send_text({KEYWORDS[20], "S"}, 1);
        send_text("selec", 0);
        send_text("and", 0);
        send_byte(8'h7F, 0, 0);
        send_byte("k", 0, 1);
        wait_drained();
        for (int c = 0; c < 256; c++)
            send_byte(8'(c), 1, 1);
        wait_drained();

        run_phase(48);
        wait_drained();
        send_idle_pct = 69;
        recv_idle_pct = 16;
        run_phase(48);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(48);
        wait_drained();

        $display("sent %0d requests, checked %0d results (%0d keyword hits)",
                 requests_sent, board.results_seen, board.hits_seen);
        $display("covered leads, delimiters, last marks, long runs, drops, idle bytes");
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/sqlkw_pkg.sv
rtl/core/sqlkw_stream_if.sv
rtl/core/sqlkw_gather.sv
rtl/core/sqlkw_match.sv
rtl/core/sql_keyword_recognizer_unit.sv
dv/sqlkw_tb_pkg.sv
dv/testbench.sv
